// ===== src/mhs_pkg.sv =====
// ----------------------------------------------------------------------------
// Mail header sniffer package
// Shared types, character codes and prefix tables for the header sniffer.
// ----------------------------------------------------------------------------
package mhs_pkg;

	// Register map.
	localparam int unsigned ADDR_BITS = 3;
	localparam int unsigned LIMIT_BITS = 10;
	localparam logic [LIMIT_BITS-1:0] SCAN_LIMIT_RESET = 10'd80;

	// Junk line rules.
	localparam int unsigned MSG_MIN_LEN = 14;
	localparam int unsigned MSG_PREFIX_LEN = 9;
	localparam int unsigned FROM_MIN_LEN = 6;
	localparam int unsigned FROM_PREFIX_LEN = 5;

	// Character codes.
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Header scan states.
	localparam logic [1:0] SCAN_START = 2'd0;
	localparam logic [1:0] SCAN_NAME = 2'd1;
	localparam logic [1:0] SCAN_COLON = 2'd2;
	localparam logic [1:0] SCAN_DONE = 2'd3;

	// Message phases.
	localparam logic PH_FIRST = 1'b0;
	localparam logic PH_AFTER = 1'b1;

	// One input item.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	// One result item, with its valid flag.
	typedef struct packed {
		logic        valid;
		logic        header_found;
		logic [15:0] discard_length;
	} result_t;

	// Characters of the "(Message " prefix.
	function automatic logic [7:0] msg_prefix_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0: c = 8'h28;
			4'd1: c = 8'h4D;
			4'd2: c = 8'h65;
			4'd3: c = 8'h73;
			4'd4: c = 8'h73;
			4'd5: c = 8'h61;
			4'd6: c = 8'h67;
			4'd7: c = 8'h65;
			default: c = CH_SPACE;
		endcase
		return c;
	endfunction

	// Characters of the "From " prefix.
	function automatic logic [7:0] from_prefix_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h46;
			3'd1: c = 8'h72;
			3'd2: c = 8'h6F;
			3'd3: c = 8'h6D;
			default: c = CH_SPACE;
		endcase
		return c;
	endfunction

endpackage

// ===== src/mhs_apb.sv =====
// ----------------------------------------------------------------------------
// Sniffer configuration port
// APB-style register block holding the header scan limit.
// ----------------------------------------------------------------------------
module mhs_apb (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mhs_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output logic [mhs_pkg::LIMIT_BITS-1:0]  scan_limit
);
	import mhs_pkg::*;

	logic [LIMIT_BITS-1:0] scan_limit_q;
	logic                  limit_sel;

	// Only one word is implemented; it answers at every address with the top bit clear (0 to 3).
	assign limit_sel = (paddr[ADDR_BITS-1] == 1'b0);

	// Scan limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_limit_q <= SCAN_LIMIT_RESET;
		end else if (psel && penable && pwrite && limit_sel) begin
			scan_limit_q <= pwdata[LIMIT_BITS-1:0];
		end
	end

	// Read data and ready.
	assign prdata = limit_sel ? {{(32-LIMIT_BITS){1'b0}}, scan_limit_q} : 32'd0;
	assign pready = 1'b1;
	assign scan_limit = scan_limit_q;

endmodule

// ===== src/mhs_step.sv =====
// ----------------------------------------------------------------------------
// Sniffer step logic
// Message state registers and the per-byte update that decides the result.
// ----------------------------------------------------------------------------
module mhs_step #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step_en,
	input  mhs_pkg::item_t                   item,
	input  logic [mhs_pkg::LIMIT_BITS-1:0]  scan_limit,
	output mhs_pkg::result_t                 result
);
	import mhs_pkg::*;

	localparam int unsigned WW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

	typedef struct packed {
		logic [1:0]            state;
		logic [LIMIT_BITS-1:0] count;
		logic                  done;
		logic                  hdr;
		logic                  other;
	} scan_t;

	// One step of the header scan over a byte.
	function automatic scan_t scan_step(input logic [1:0] st,
		input logic [LIMIT_BITS-1:0] cnt, input logic done, input logic hdr,
		input logic [7:0] b, input logic [LIMIT_BITS-1:0] lim);
		scan_t r;
		logic  is_alpha;
		logic  is_digit;
		r.state = st;
		r.count = cnt;
		r.done = done;
		r.hdr = hdr;
		r.other = 1'b0;
		is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
		is_digit = ((b >= 8'h30) && (b <= 8'h39)) || (b == CH_DASH);
		if (!done) begin
			if (cnt >= lim) begin
				r.done = 1'b1;
				r.hdr = 1'b0;
			end else begin
				r.count = cnt + 1'b1;
				priority if (is_alpha) begin
					r.state = (st == SCAN_START || st == SCAN_NAME) ? SCAN_NAME : SCAN_DONE;
				end else if (is_digit) begin
					r.state = (st == SCAN_NAME) ? SCAN_NAME : SCAN_DONE;
				end else if (b == CH_COLON) begin
					r.state = (st == SCAN_NAME) ? SCAN_COLON : SCAN_DONE;
				end else if (b == CH_SPACE) begin
					r.hdr = (st == SCAN_COLON);
					r.state = SCAN_DONE;
				end else begin
					r.state = SCAN_DONE;
					r.other = 1'b1;
				end
				if (r.state == SCAN_DONE || r.count >= lim) begin
					r.done = 1'b1;
				end
			end
		end
		return r;
	endfunction

	logic                   phase_q, phase_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [1:0]             flags_q, flags_d;
	logic [7:0]             lb0_q, lb0_d, lb1_q, lb1_d;
	logic [1:0]             scan_st_q, scan_st_d;
	logic [LIMIT_BITS-1:0]  scan_cnt_q, scan_cnt_d;
	logic                   done_q, done_d, hdr_q, hdr_d;
	logic                   decided_q, decided_d;

	scan_t                  sc;
	logic [LENGTH_BITS-1:0] len_inc;
	logic [WW-1:0]          len_cur_w, len_inc_w, len_sc_w;
	logic [WW-1:0]          sat_cur, sat_inc, sat_sc;
	logic                   junk_eos, junk_lf;
	logic [1:0]             flags_n;
	logic [7:0]             b;

	// Saturating length and its clamped 16-bit views.
	assign len_inc = (len_q == {LENGTH_BITS{1'b1}}) ? len_q : len_q + 1'b1;
	assign len_cur_w = WW'(len_q);
	assign len_inc_w = WW'(len_inc);
	assign sat_cur = (len_cur_w > WW'(16'hFFFF)) ? WW'(16'hFFFF) : len_cur_w;
	assign sat_inc = (len_inc_w > WW'(16'hFFFF)) ? WW'(16'hFFFF) : len_inc_w;
	assign len_sc_w = sc.other ? '0 : len_cur_w;
	assign sat_sc = (len_sc_w > WW'(16'hFFFF)) ? WW'(16'hFFFF) : len_sc_w;

	assign b = item.data_byte;
	assign sc = scan_step(scan_st_q, scan_cnt_q, done_q, hdr_q, b, scan_limit);

	// Prefix match flags after this byte.
	always_comb begin
		flags_n = flags_q;
		if (len_cur_w < WW'(MSG_PREFIX_LEN) && b != msg_prefix_char(len_q[3:0])) begin
			flags_n[0] = 1'b0;
		end
		if (len_cur_w < WW'(FROM_PREFIX_LEN) && b != from_prefix_char(len_q[2:0])) begin
			flags_n[1] = 1'b0;
		end
	end

	// Junk line tests at end of stream and at the first newline.
	assign junk_eos = (len_cur_w >= WW'(MSG_MIN_LEN) && flags_q[0] && lb1_q == CH_RPAREN)
		|| (len_cur_w >= WW'(FROM_MIN_LEN) && flags_q[1]);
	assign junk_lf = (len_inc_w >= WW'(MSG_MIN_LEN) && flags_n[0] && lb0_q == CH_RPAREN)
		|| (len_inc_w >= WW'(FROM_MIN_LEN) && flags_n[1]);

	// Next state and result for the item in the input register.
	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		flags_d = flags_q;
		lb0_d = lb0_q;
		lb1_d = lb1_q;
		scan_st_d = scan_st_q;
		scan_cnt_d = scan_cnt_q;
		done_d = done_q;
		hdr_d = hdr_q;
		decided_d = decided_q;
		result = '0;
		if (item.end_of_stream) begin
			if (!decided_q) begin
				result.valid = 1'b1;
				if (phase_q == PH_FIRST) begin
					result.header_found = junk_eos ? 1'b0 : hdr_q;
					result.discard_length = junk_eos ? sat_cur[15:0] : 16'd0;
				end else begin
					result.header_found = hdr_q;
					result.discard_length = sat_cur[15:0];
				end
			end
			phase_d = PH_FIRST;
			len_d = '0;
			flags_d = 2'b11;
			lb0_d = 8'd0;
			lb1_d = 8'd0;
			scan_st_d = SCAN_START;
			scan_cnt_d = '0;
			done_d = 1'b0;
			hdr_d = 1'b0;
			decided_d = 1'b0;
		end else if (!decided_q) begin
			scan_st_d = sc.state;
			scan_cnt_d = sc.count;
			done_d = sc.done;
			hdr_d = sc.hdr;
			if (phase_q == PH_FIRST) begin
				flags_d = flags_n;
				len_d = len_inc;
				lb1_d = lb0_q;
				lb0_d = b;
				if (b == CH_LF) begin
					if (!junk_lf) begin
						result.valid = 1'b1;
						result.header_found = sc.hdr;
					end else begin
						// Junk line closed: restart the scan after it.
						phase_d = PH_AFTER;
						scan_st_d = SCAN_START;
						done_d = 1'b0;
						hdr_d = 1'b0;
						scan_cnt_d = len_inc_w[LIMIT_BITS-1:0];
						if (len_inc_w >= WW'(scan_limit)) begin
							result.valid = 1'b1;
							result.discard_length = sat_inc[15:0];
						end
					end
				end else if (flags_n == 2'b00 && sc.done) begin
					result.valid = 1'b1;
					result.header_found = sc.hdr;
				end
			end else begin
				len_d = len_sc_w[LENGTH_BITS-1:0];
				if (sc.done) begin
					result.valid = 1'b1;
					result.header_found = sc.hdr;
					result.discard_length = sat_sc[15:0];
				end
			end
			if (result.valid) begin
				decided_d = 1'b1;
			end
		end
	end

	// Message state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			len_q <= '0;
			flags_q <= 2'b11;
			lb0_q <= 8'd0;
			lb1_q <= 8'd0;
			scan_st_q <= SCAN_START;
			scan_cnt_q <= '0;
			done_q <= 1'b0;
			hdr_q <= 1'b0;
			decided_q <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			len_q <= len_d;
			flags_q <= flags_d;
			lb0_q <= lb0_d;
			lb1_q <= lb1_d;
			scan_st_q <= scan_st_d;
			scan_cnt_q <= scan_cnt_d;
			done_q <= done_d;
			hdr_q <= hdr_d;
			decided_q <= decided_d;
		end
	end

	// Once decided, only end of stream may change anything, and it gives no result.
	a_no_result_after_decision: assert property (@(posedge clk) disable iff (!arst_n)
		decided_q |-> !result.valid)
		else $error("result produced after the message was decided");

	// A pending junk line is always long enough to be one.
	a_junk_length: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_AFTER && !decided_q) |-> (len_cur_w >= WW'(FROM_MIN_LEN)))
		else $error("after-junk phase with a short line length");

	// A header is only reported by a finished scan.
	a_hdr_done: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_q |-> done_q)
		else $error("header flag set while the scan is still running");

endmodule

// ===== src/mail_header_sniffer.sv =====
// ----------------------------------------------------------------------------
// Mail header sniffer
// Decides whether a message starts with a header line and how long a
// leading mailer junk line is.
// ----------------------------------------------------------------------------
//   Channel   Handshake                     Payload
//   item      item_valid / item_ready       data_byte, end_of_stream
//   result    result_valid / result_ready   header_found, discard_length
//   config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One item is taken per cycle while no result is held waiting; the byte update
// is one pass of logic between the input register and the result register, so
// the result register is loaded by the edge that moves its item on from the input
// register. While a result waits, the input register can take one item and then
// stalls until the result is taken. Reset empties both registers, rearms the
// message state and sets the scan limit to 80. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module mail_header_sniffer #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mhs_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           end_of_stream,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic                           header_found,
	output logic [15:0]                    discard_length
);
	import mhs_pkg::*;

	logic                  valid_s1;
	item_t                 item_s1;
	logic                  fire;
	logic [LIMIT_BITS-1:0] scan_limit;
	result_t               step_res;
	logic                  result_valid_q;
	logic                  header_found_q;
	logic [15:0]           discard_length_q;

	mhs_apb u_apb (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.scan_limit (scan_limit)
	);

	// The held item moves on when the result register is free or emptying.
	assign fire = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1.data_byte <= data_byte;
			item_s1.end_of_stream <= end_of_stream;
		end
	end

	mhs_step #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (fire),
		.item       (item_s1),
		.scan_limit (scan_limit),
		.result     (step_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire && step_res.valid) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && step_res.valid) begin
			header_found_q <= step_res.header_found;
			discard_length_q <= step_res.discard_length;
		end
	end

	assign result_valid = result_valid_q;
	assign header_found = header_found_q;
	assign discard_length = discard_length_q;

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_ready) |-> !fire)
		else $error("result register overwritten while stalled");

	// An empty input register always takes the next item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item_ready)
		else $error("input register empty but not ready");

	// A stalled held item stays in place.
	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |=> (valid_s1 && $stable(item_s1)))
		else $error("held item lost while stalled");

endmodule

// ===== tb/sv/tb_mail_header_sniffer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mail header sniffer testbench
// Streams messages byte by byte into the sniffer and checks every result
// against a cycle-free model of the junk line and header scan rules. It runs
// directed messages and random messages under several scan limits (with and
// without idle cycles on either side).
// ----------------------------------------------------------------------------
module tb_mail_header_sniffer;
	import mhs_pkg::*;

	localparam int unsigned LEN_MAX = 65535;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam logic [ADDR_BITS-1:0] ADDR_SCAN_LIMIT = 3'd0;
	localparam logic [8*9-1:0] MSG_TAG = "(Message ";
	localparam logic [8*5-1:0] FROM_TAG = "From ";

	// One expected result item.
	typedef struct packed {
		logic        hdr;
		logic [15:0] disc;
	} sniff_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_stream = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        header_found;
	logic [15:0] discard_length;

	// Predictor state: a copy of the message state and the scan limit.
	logic [9:0]  lim_q;
	logic        phase_q;
	logic [15:0] line_len;
	logic [1:0]  tag_live;      // bit 0: "(Message " still matches, bit 1: "From "
	logic [7:0]  prev_byte;
	logic [7:0]  prev2_byte;
	logic [1:0]  scan_st;
	logic [15:0] scan_cnt;
	logic        scan_done;
	logic        scan_hdr;
	logic        decided;
	sniff_res_t  want_q[$];

	logic [7:0]  msg_bytes[$];
	logic        idle_on = 1'b1;
	int unsigned sent_items = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	mail_header_sniffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.header_found(header_found),
		.discard_length(discard_length)
	);

	always #5 clk = ~clk;

	// Run length guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_mail_header_sniffer NOT OK");
			$finish;
		end
	end

	// The result side stalls at random unless idling is switched off.
	always @(posedge clk) begin
		result_ready <= idle_on ? ($urandom_range(0, 99) >= 16) : 1'b1;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Return the message state to its value after reset.
	task automatic rearm_predictor();
		phase_q = PH_FIRST;
		line_len = '0;
		tag_live = 2'b11;
		prev_byte = 8'h00;
		prev2_byte = 8'h00;
		scan_st = SCAN_START;
		scan_cnt = '0;
		scan_done = 1'b0;
		scan_hdr = 1'b0;
		decided = 1'b0;
	endtask

	task automatic push_result(input logic hdr, input logic [15:0] disc);
		sniff_res_t r;
		r.hdr = hdr;
		r.disc = disc;
		want_q.insert(want_q.size(), r);
		decided = 1'b1;
	endtask

	// One step of the header name scan; flags a byte that is no header character.
	task automatic scan_header_byte(input logic [7:0] b, output logic other);
		logic hdr;
		other = 1'b0;
		hdr = 1'b0;
		if (scan_done)
			return;
		if (scan_cnt >= lim_q) begin
			scan_done = 1'b1;
			scan_hdr = 1'b0;
			return;
		end
		scan_cnt = scan_cnt + 16'd1;
		if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) begin
			scan_st = (scan_st == SCAN_START || scan_st == SCAN_NAME) ? SCAN_NAME : SCAN_DONE;
		end else if ((b >= "0" && b <= "9") || b == CH_DASH) begin
			scan_st = (scan_st == SCAN_NAME) ? SCAN_NAME : SCAN_DONE;
		end else if (b == CH_COLON) begin
			scan_st = (scan_st == SCAN_NAME) ? SCAN_COLON : SCAN_DONE;
		end else if (b == CH_SPACE) begin
			hdr = (scan_st == SCAN_COLON);
			scan_st = SCAN_DONE;
		end else begin
			scan_st = SCAN_DONE;
			other = 1'b1;
		end
		if (scan_st == SCAN_DONE || scan_cnt >= lim_q) begin
			scan_done = 1'b1;
			scan_hdr = hdr;
		end
	endtask

	// Advance the predictor by one accepted item and queue any result it causes.
	task automatic sniff_step(input logic [7:0] b, input logic eos);
		logic junk;
		logic other;
		junk = 1'b0;
		if (eos) begin
			if (!decided) begin
				if (phase_q == PH_FIRST) begin
					junk = (line_len >= MSG_MIN_LEN && tag_live[0] && prev2_byte == CH_RPAREN)
						|| (line_len >= FROM_MIN_LEN && tag_live[1]);
					if (junk)
						push_result(1'b0, line_len);
					else
						push_result(scan_hdr, 16'd0);
				end else begin
					push_result(scan_hdr, line_len);
				end
			end
			rearm_predictor();
			return;
		end
		if (decided)
			return;

		if (phase_q == PH_FIRST) begin
			// Prefix tracking over the first line.
			if (line_len < MSG_PREFIX_LEN) begin
				if (b != MSG_TAG[8*(MSG_PREFIX_LEN-1-line_len) +: 8])
					tag_live[0] = 1'b0;
			end
			if (line_len < FROM_PREFIX_LEN) begin
				if (b != FROM_TAG[8*(FROM_PREFIX_LEN-1-line_len) +: 8])
					tag_live[1] = 1'b0;
			end
			if (line_len != LEN_MAX)
				line_len = line_len + 16'd1;
			scan_header_byte(b, other);
			if (b == CH_LF) begin
				junk = (line_len >= MSG_MIN_LEN && tag_live[0] && prev_byte == CH_RPAREN)
					|| (line_len >= FROM_MIN_LEN && tag_live[1]);
				prev2_byte = prev_byte;
				prev_byte = b;
				if (!junk) begin
					push_result(scan_hdr, 16'd0);
					return;
				end
				// A junk line: restart the scan behind it, its bytes counted.
				phase_q = PH_AFTER;
				scan_st = SCAN_START;
				scan_done = 1'b0;
				scan_hdr = 1'b0;
				scan_cnt = line_len;
				if (scan_cnt >= lim_q)
					push_result(1'b0, line_len);
				return;
			end
			prev2_byte = prev_byte;
			prev_byte = b;
			// Early decision once no prefix can match and the scan is over.
			if (tag_live == 2'b00 && scan_done)
				push_result(scan_hdr, 16'd0);
		end else begin
			scan_header_byte(b, other);
			if (other)
				line_len = '0;
			if (scan_done)
				push_result(scan_hdr, line_len);
		end
	endtask

	// Send one item, with random idle cycles ahead of it while idling is on.
	task automatic send_item(input logic [7:0] b, input logic eos);
		if (idle_on) begin
			while ($urandom_range(0, 99) < 16) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		do @(posedge clk); while (!item_ready);
		sent_items++;
		sniff_step(b, eos);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	// Let the block empty out: no item pending, all results back, pipeline idle.
	task automatic drain();
		item_valid <= 1'b0;
		while (want_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the scan limit over the register port and read it back.
	task automatic set_scan_limit(input logic [9:0] limit);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_SCAN_LIMIT;
		pwdata <= {22'd0, limit};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		lim_q = limit;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {22'd0, limit})
			report_mismatch($sformatf("scan limit reads %0h, wrote %0h", prdata, limit));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] pick_letter();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(8'h41, 8'h5A));
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	function automatic logic [7:0] pick_name_char();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return pick_letter();
		if (r < 9)
			return 8'($urandom_range(8'h30, 8'h39));
		return CH_DASH;
	endfunction

	// Any byte except a line feed.
	function automatic logic [7:0] pick_text_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		return (c == CH_LF) ? CH_SPACE : c;
	endfunction

	// Append one byte to the message being built.
	task automatic add_byte(input logic [7:0] c);
		msg_bytes.insert(msg_bytes.size(), c);
	endtask

	task automatic add_text(input int unsigned n);
		repeat (n) add_byte(pick_text_char());
	endtask

	task automatic add_noise(input int unsigned n);
		repeat (n) add_byte(8'($urandom_range(0, 255)));
	endtask

	// A header start, now and then with pieces broken at random.
	task automatic add_header_line();
		int unsigned n;
		n = $urandom_range(0, 12);
		add_byte($urandom_range(0, 9) ? pick_letter() : pick_name_char());
		repeat (n) add_byte(pick_name_char());
		add_byte($urandom_range(0, 19) ? CH_COLON : pick_text_char());
		add_byte($urandom_range(0, 9) ? CH_SPACE : pick_name_char());
		add_text($urandom_range(0, 4));
	endtask

	// A junk prefix at the start of the message, maybe with one byte changed.
	task automatic add_prefix(input string s, input logic mutate);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
		if (mutate)
			msg_bytes[$urandom_range(0, s.len() - 1)] = pick_text_char();
	endtask

	// Build one random message: mostly well-formed, some broken, some noise.
	task automatic build_message();
		int unsigned kind;
		logic open_end;
		msg_bytes.delete();
		open_end = 1'b0;
		kind = $urandom_range(0, 99);
		if (kind < 25) begin
			add_header_line();
		end else if (kind < 45) begin
			add_prefix("From ", $urandom_range(0, 7) == 0);
			add_text($urandom_range(0, 6));
			open_end = ($urandom_range(0, 9) == 0);
			if (!open_end)
				add_byte(CH_LF);
		end else if (kind < 70) begin
			add_prefix("(Message ", $urandom_range(0, 7) == 0);
			add_text($urandom_range(0, 8));
			add_byte($urandom_range(0, 7) ? CH_RPAREN : pick_text_char());
			open_end = ($urandom_range(0, 9) == 0);
			add_byte(open_end ? pick_text_char() : CH_LF);
		end else if (kind < 85) begin
			// A name that breaks off on a stray character.
			repeat ($urandom_range(0, 6)) add_byte(pick_name_char());
			add_byte(pick_text_char());
			add_text($urandom_range(0, 4));
		end else begin
			add_noise($urandom_range(1, 12));
		end
		// The line after a junk candidate.
		if (kind >= 25 && kind < 70 && !open_end) begin
			if ($urandom_range(0, 3))
				add_header_line();
			else
				add_noise($urandom_range(1, 6));
		end
		if (!open_end)
			add_text($urandom_range(0, 3));
	endtask

	task automatic send_message();
		foreach (msg_bytes[i])
			send_item(msg_bytes[i], 1'b0);
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Short hand-picked messages under the reset scan limit.
	task automatic test_directed_cases();
		// Header at byte 0, decided early.
		send_text("A: ");
		send_item(8'hFF, 1'b1);
		// Sender line, then a header behind it.
		send_text("From \nB: ");
		send_item(8'h00, 1'b1);
		// Sender line, then a stray byte that cancels the discard.
		send_text("From \n");
		send_item(8'h00, 1'b0);
		send_item(8'h5A, 1'b1);
		// Empty message.
		send_item(8'hA5, 1'b1);
		// Stray byte first: decided at once, end of stream gives nothing more.
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
	endtask

	// Random messages under one scan limit.
	task automatic test_random_messages(input logic [9:0] limit, input int unsigned n_items,
		input logic quiet);
		int unsigned start;
		set_scan_limit(limit);
		idle_on = !quiet;
		start = sent_items;
		while (sent_items - start < n_items) begin
			build_message();
			send_message();
		end
		idle_on = 1'b1;
	endtask

	// Compare each result with the oldest expected one.
	always @(posedge clk) begin : result_check
		sniff_res_t due;
		if (arst_n && result_valid && result_ready) begin
			if (want_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result hdr=%0b disc=%0d",
					header_found, discard_length));
			end else begin
				due = want_q.pop_front();
				if (header_found !== due.hdr)
					report_mismatch($sformatf("header_found %0b, want %0b",
						header_found, due.hdr));
				if (discard_length !== due.disc)
					report_mismatch($sformatf("discard_length %0d, want %0d",
						discard_length, due.disc));
			end
		end
	end

	initial begin
		lim_q = SCAN_LIMIT_RESET;
		rearm_predictor();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_messages(SCAN_LIMIT_RESET, 200, 1'b0);
		test_random_messages(10'd0, 150, 1'b0);
		test_random_messages(10'd1, 150, 1'b0);
		test_random_messages(10'd1023, 200, 1'b0);
		test_random_messages(10'($urandom_range(2, 20)), 250, 1'b0);
		test_random_messages(10'($urandom_range(1, 1023)), 200, 1'b0);
		// Long stretch with both sides always willing.
		test_random_messages(10'($urandom_range(4, 40)), 250, 1'b1);

		drain();
		if (mismatches == 0)
			$display("tb_mail_header_sniffer OK");
		else
			$display("tb_mail_header_sniffer NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
src/mhs_pkg.sv
src/mhs_apb.sv
src/mhs_step.sv
src/mail_header_sniffer.sv
tb/sv/tb_mail_header_sniffer.sv
